// ----- sv/rsa_pkg.sv -----
// ============================================================================
// rsa_pkg: shared types and constants for the rule slot allocator
// Slot table sizing, request and status codes, controller/datapath links.
// ============================================================================
package rsa_pkg;

    localparam int SLOTS      = 256;
    localparam int SLOT_AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W      = SLOT_AW + 1;
    localparam int CFG_W      = 9;
    localparam int LIM_W      = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int KEY_W      = 64;
    localparam int IDX_W      = 16;
    localparam int SLOT_OUT_W = 8;
    localparam int CFG_RESET  = 256;

    typedef enum logic [1:0] {
        MODE_ALLOC  = 2'd0,
        MODE_FREE   = 2'd1,
        MODE_LOOKUP = 2'd2,
        MODE_QUERY  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EXISTING  = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    // controller -> datapath
    typedef struct packed {
        logic load;    // take the request
        logic rd;      // issue a key read at the scan address
        logic cmp;     // compare the returned key
        logic commit;  // update table and load the result register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic rd_done;   // last address already issued
        logic match;     // live slot holds the key
        logic cmp_last;  // last slot is being compared
        logic out_free;  // result register can take a new result
    } t_sts;

endpackage

// ----- sv/rsa_ram.sv -----
// ============================================================================
// rsa_ram: generic single-port RAM
// One read or write per cycle, registered read data.
// ============================================================================
module rsa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                                     i_clk,
    input  logic                                     i_en,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  logic [WIDTH-1:0]                         i_wdata,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/rsa_ctrl.sv -----
// ============================================================================
// rsa_ctrl: request sequencer
// Steps a request through accept, key scan and commit; a live query skips the scan.
// ============================================================================
module rsa_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  rsa_pkg::t_mode i_mode,
    input  rsa_pkg::t_sts  i_sts,
    output rsa_pkg::t_cmd  o_cmd
);
    import rsa_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_COMMIT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = (i_mode == MODE_QUERY) ? S_COMMIT : S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.rd  = !i_sts.rd_done;
                o_cmd.cmp = 1'b1;
                if (i_sts.match || i_sts.cmp_last) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    // a scan only ends on a compare
    a_scan_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && n_state == S_COMMIT) |-> (i_sts.match || i_sts.cmp_last))
        else $error("scan left without a match or the last compare");

    // commit is only issued while the result register has room
    a_commit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> i_sts.out_free)
        else $error("commit while result register is busy");

    // a new request is never taken in the cycle of a commit
    a_load_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> !$past(o_cmd.load))
        else $error("load and commit overlapped");

endmodule

// ----- sv/rsa_dp.sv -----
// ============================================================================
// rsa_dp: slot table datapath
// Key memory, live bits, scan pointer, match/free tracking, result register.
// ============================================================================
module rsa_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rsa_pkg::t_cmd                 i_cmd,
    output rsa_pkg::t_sts                 o_sts,
    input  logic                          i_cfg_valid,
    input  logic [rsa_pkg::CFG_W-1:0]     i_cfg_data,
    input  rsa_pkg::t_mode                i_mode,
    input  logic [rsa_pkg::KEY_W-1:0]     i_rule_key,
    input  logic [rsa_pkg::IDX_W-1:0]     i_slot_index,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [rsa_pkg::SLOT_OUT_W-1:0] o_slot,
    output logic [1:0]                    o_status,
    output logic                          o_is_live,
    output logic                          o_clear_row
);
    import rsa_pkg::*;

    localparam logic [SLOT_AW-1:0] LAST_ADDR = SLOT_AW'(SLOTS - 1);

    // configuration
    logic [CFG_W-1:0] r_slots_in_use;
    logic [LIM_W-1:0] lim;

    // request
    t_mode            r_mode;
    logic [KEY_W-1:0] r_key;
    logic [IDX_W-1:0] r_idx;

    // scan
    logic [SLOT_AW-1:0] r_rd_addr;
    logic               r_rd_done;
    logic [SLOT_AW-1:0] r_cmp_addr;
    logic               r_cmp_valid;
    logic               r_hit;
    logic [SLOT_AW-1:0] r_hit_addr;
    logic               r_free_found;
    logic [SLOT_AW-1:0] r_free_addr;
    logic [SLOTS-1:0]   r_live;

    // memory
    logic               ram_en;
    logic               ram_we;
    logic [SLOT_AW-1:0] ram_addr;
    logic [KEY_W-1:0]   ram_rdata;

    // result
    logic                  r_out_valid;
    logic [SLOT_OUT_W-1:0] r_slot;
    t_status               r_status;
    logic                  r_is_live;
    logic                  r_clear_row;

    logic [SLOT_AW-1:0]    n_slot_addr;
    t_status               n_status;
    logic                  n_is_live;
    logic                  n_clear_row;
    logic                  set_live;
    logic                  clr_live;
    logic [SLOT_AW+SLOT_OUT_W-1:0] slot_ext;
    logic                  free_cand;

    assign lim = (LIM_W'(r_slots_in_use) > LIM_W'(SLOTS)) ? LIM_W'(SLOTS)
                                                          : LIM_W'(r_slots_in_use);

    assign o_sts.rd_done  = r_rd_done;
    assign o_sts.match    = i_cmd.cmp && r_cmp_valid && r_live[r_cmp_addr]
                            && (ram_rdata == r_key);
    assign o_sts.cmp_last = r_cmp_valid && (r_cmp_addr == LAST_ADDR);
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign free_cand = i_cmd.cmp && r_cmp_valid && !r_free_found && !r_live[r_cmp_addr]
                       && (LIM_W'(r_cmp_addr) < lim);

    // commit decode
    always_comb begin
        n_slot_addr = '0;
        n_status    = ST_OK;
        n_is_live   = 1'b0;
        n_clear_row = 1'b0;
        set_live    = 1'b0;
        clr_live    = 1'b0;
        case (r_mode)
            MODE_ALLOC: begin
                if (r_hit) begin
                    n_slot_addr = r_hit_addr;
                    n_status    = ST_EXISTING;
                end else if (r_free_found) begin
                    n_slot_addr = r_free_addr;
                    n_clear_row = 1'b1;
                    set_live    = 1'b1;
                end else begin
                    n_status = ST_FULL;
                end
            end
            MODE_FREE: begin
                if (r_hit) begin
                    n_slot_addr = r_hit_addr;
                    clr_live    = 1'b1;
                end else begin
                    n_status = ST_NOT_FOUND;
                end
            end
            MODE_LOOKUP: begin
                if (r_hit) begin
                    n_slot_addr = r_hit_addr;
                end else begin
                    n_status = ST_NOT_FOUND;
                end
            end
            MODE_QUERY: begin
                n_is_live = (r_idx < IDX_W'(lim)) && r_live[r_idx[SLOT_AW-1:0]];
            end
            default: n_status = ST_OK;
        endcase
    end

    assign slot_ext = {{SLOT_OUT_W{1'b0}}, n_slot_addr};

    // key memory: scan reads, new-claim writes
    assign ram_we   = i_cmd.commit && set_live;
    assign ram_en   = i_cmd.rd || ram_we;
    assign ram_addr = ram_we ? r_free_addr : r_rd_addr;

    rsa_ram #(
        .WIDTH (KEY_W),
        .DEPTH (SLOTS)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_en    (ram_en),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (r_key),
        .o_rdata (ram_rdata)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slots_in_use <= CFG_W'(CFG_RESET);
            r_live         <= '0;
            r_rd_done      <= 1'b0;
            r_cmp_valid    <= 1'b0;
            r_hit          <= 1'b0;
            r_free_found   <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_slots_in_use <= i_cfg_data;
            end
            if (i_cmd.load) begin
                r_rd_done    <= 1'b0;
                r_cmp_valid  <= 1'b0;
                r_hit        <= 1'b0;
                r_free_found <= 1'b0;
            end else begin
                r_cmp_valid <= i_cmd.rd;
                if (i_cmd.rd && r_rd_addr == LAST_ADDR) begin
                    r_rd_done <= 1'b1;
                end
                if (o_sts.match && !r_hit) begin
                    r_hit <= 1'b1;
                end
                if (free_cand) begin
                    r_free_found <= 1'b1;
                end
            end
            if (i_cmd.commit && set_live) begin
                r_live[r_free_addr] <= 1'b1;
            end
            if (i_cmd.commit && clr_live) begin
                r_live[r_hit_addr] <= 1'b0;
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode    <= i_mode;
            r_key     <= i_rule_key;
            r_idx     <= i_slot_index;
            r_rd_addr <= '0;
        end else if (i_cmd.rd) begin
            r_rd_addr <= r_rd_addr + SLOT_AW'(1);
        end
        if (i_cmd.rd) begin
            r_cmp_addr <= r_rd_addr;
        end
        if (o_sts.match && !r_hit) begin
            r_hit_addr <= r_cmp_addr;
        end
        if (free_cand) begin
            r_free_addr <= r_cmp_addr;
        end
        if (i_cmd.commit) begin
            r_slot      <= slot_ext[SLOT_OUT_W-1:0];
            r_status    <= n_status;
            r_is_live   <= n_is_live;
            r_clear_row <= n_clear_row;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_slot      = r_slot;
    assign o_status    = r_status;
    assign o_is_live   = r_is_live;
    assign o_clear_row = r_clear_row;

    // a newly claimed slot was free at claim time and is live afterwards
    a_claim_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && set_live) |-> !r_live[r_free_addr])
        else $error("claimed slot already live");

    a_claim_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && set_live) |=> r_live[$past(r_free_addr)])
        else $error("claimed slot not marked live");

    // full and not-found results carry slot 0 and no row clear
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_status == ST_FULL || r_status == ST_NOT_FOUND))
        |-> (r_slot == '0 && !r_clear_row))
        else $error("failed request with nonzero slot or row clear");

endmodule

// ----- sv/rule_slot_allocator.sv -----
// ============================================================================
// rule_slot_allocator: lowest-free-slot allocator with a rule key map
// Live bits plus a 64-bit key memory per slot; allocate, free, look up and
// live query requests, one result transaction per request.
// ============================================================================
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-------------------------------
//  in      | to block  | i_in_valid / o_in_ready   | i_mode, i_rule_key, i_slot_index
//  out     | from block| o_out_valid / i_out_ready | o_slot, o_status, o_is_live,
//          |           |                           | o_clear_row
//  cfg     | to block  | i_cfg_valid / o_cfg_ready | i_cfg_data (slots_in_use)
//
//  A live query goes from accept straight to its commit step. Allocate, free
//  and look up scan the key memory one slot per cycle through its single read
//  port and stop at the first match or at the last slot, then commit. An
//  allocate of an unheld key always scans the whole table, since the lowest
//  free slot is tracked during that scan. One request is in flight at a
//  time; o_in_ready is high only while idle. A finished result sits in the
//  output register, and the next request is accepted while it waits. A
//  stalled output holds the sequencer in its commit step, so table updates
//  happen only when the result can be stored. Reset clears all live bits
//  at once; the key memory needs no clearing since a key is only trusted
//  from a live slot. slots_in_use resets to 256.
//  The cfg port is always ready; writes are expected only while idle.
//
module rule_slot_allocator (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // request
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [1:0]                     i_mode,
    input  logic [rsa_pkg::KEY_W-1:0]      i_rule_key,
    input  logic [rsa_pkg::IDX_W-1:0]      i_slot_index,
    // result
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [rsa_pkg::SLOT_OUT_W-1:0] o_slot,
    output logic [1:0]                     o_status,
    output logic                           o_is_live,
    output logic                           o_clear_row,
    // configuration
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [rsa_pkg::CFG_W-1:0]      i_cfg_data
);
    import rsa_pkg::*;

    t_cmd  cmd;
    t_sts  sts;
    t_mode mode;

    assign mode        = t_mode'(i_mode);
    assign o_cfg_ready = 1'b1;

    // sequencer: idle -> scan -> commit (a live query skips the scan)
    rsa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_mode     (mode),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // table, scan tracking and result register
    rsa_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_mode       (mode),
        .i_rule_key   (i_rule_key),
        .i_slot_index (i_slot_index),
        .i_out_ready  (i_out_ready),
        .o_out_valid  (o_out_valid),
        .o_slot       (o_slot),
        .o_status     (o_status),
        .o_is_live    (o_is_live),
        .o_clear_row  (o_clear_row)
    );

endmodule

// ----- tb/rsa_checker.sv -----
// ============================================================================
// rsa_checker: result predictor and scoreboard for rule_slot_allocator
// Watches the request, result and register channels, keeps its own copy of
// the slot table, and compares every result transaction field by field.
// ============================================================================
module rsa_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  logic [1:0]                     i_mode,
    input  logic [rsa_pkg::KEY_W-1:0]      i_rule_key,
    input  logic [rsa_pkg::IDX_W-1:0]      i_slot_index,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  logic [rsa_pkg::SLOT_OUT_W-1:0] i_slot,
    input  logic [1:0]                     i_status,
    input  logic                           i_is_live,
    input  logic                           i_clear_row,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [rsa_pkg::CFG_W-1:0]      i_cfg_data,
    output int                             o_error_count,
    output int                             o_outstanding
);
    import rsa_pkg::*;

    typedef struct packed {
        logic [SLOT_OUT_W-1:0] slot;
        t_status               status;
        logic                  is_live;
        logic                  clear_row;
    } t_reply;

    logic [KEY_W-1:0] key_table [SLOTS];
    logic [SLOTS-1:0] live_map;
    logic [CFG_W-1:0] slots_cfg;
    t_reply           reply_q [$];
    int               errors;
    int               reply_no;

    assign o_error_count = errors;

    task automatic report_mismatch(input string msg);
        $display("[%0t] reply %0d: %s", $time, reply_no, msg);
        errors++;
    endtask

    // lowest live slot that holds the key, -1 if none (whole table, not the limit)
    function automatic int key_holder(input logic [KEY_W-1:0] key);
        for (int s = 0; s < SLOTS; s++) begin
            if (live_map[s] && key_table[s] == key) begin
                return s;
            end
        end
        return -1;
    endfunction

    function automatic t_reply predict_reply(input t_mode mode, input logic [KEY_W-1:0] key,
                                             input logic [IDX_W-1:0] idx);
        t_reply r;
        int     hit;
        int     lim;
        bit     claimed;
        r         = '0;
        r.status  = ST_OK;
        lim       = (int'(slots_cfg) > SLOTS) ? SLOTS : int'(slots_cfg);
        hit       = key_holder(key);
        claimed   = 1'b0;
        case (mode)
            MODE_ALLOC: begin
                if (hit >= 0) begin
                    r.slot   = SLOT_OUT_W'(hit);
                    r.status = ST_EXISTING;
                end else begin
                    r.status = ST_FULL;
                    for (int s = 0; s < lim && !claimed; s++) begin
                        if (!live_map[s]) begin
                            live_map[s]  = 1'b1;
                            key_table[s] = key;
                            r.slot       = SLOT_OUT_W'(s);
                            r.status     = ST_OK;
                            r.clear_row  = 1'b1;
                            claimed      = 1'b1;
                        end
                    end
                end
            end
            MODE_FREE: begin
                if (hit >= 0) begin
                    live_map[hit] = 1'b0;
                    r.slot        = SLOT_OUT_W'(hit);
                end else begin
                    r.status = ST_NOT_FOUND;
                end
            end
            MODE_LOOKUP: begin
                if (hit >= 0) begin
                    r.slot = SLOT_OUT_W'(hit);
                end else begin
                    r.status = ST_NOT_FOUND;
                end
            end
            default: begin
                if (int'(idx) < lim) begin
                    r.is_live = live_map[idx];
                end
            end
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_reply want;
        logic   in_acc;
        logic   out_acc;
        in_acc  = i_in_valid && i_in_ready;
        out_acc = i_out_valid && i_out_ready;
        if (!i_rst_n) begin
            live_map  = '0;
            slots_cfg = CFG_W'(CFG_RESET);
            reply_q.delete();
            errors    = 0;
            reply_no  = 0;
            o_outstanding <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                slots_cfg = i_cfg_data;
            end
            if (out_acc) begin
                if (reply_q.size() == 0) begin
                    report_mismatch("result with no request outstanding");
                end else begin
                    want = reply_q.pop_front();
                    if (i_slot !== want.slot) begin
                        report_mismatch($sformatf("slot got %0d want %0d", i_slot, want.slot));
                    end
                    if (i_status !== want.status) begin
                        report_mismatch($sformatf("status got %0d want %0d",
                                                  i_status, want.status));
                    end
                    if (i_is_live !== want.is_live) begin
                        report_mismatch($sformatf("is_live got %b want %b",
                                                  i_is_live, want.is_live));
                    end
                    if (i_clear_row !== want.clear_row) begin
                        report_mismatch($sformatf("clear_row got %b want %b",
                                                  i_clear_row, want.clear_row));
                    end
                end
                reply_no++;
            end
            if (in_acc) begin
                reply_q.push_back(predict_reply(t_mode'(i_mode), i_rule_key, i_slot_index));
            end
            o_outstanding <= reply_q.size();
        end
    end

endmodule

// ----- tb/testbench.sv -----
// ============================================================================
// testbench: top level for rule_slot_allocator verification
// Drives directed and random request streams under several slot limits and
// idle patterns; rsa_checker predicts and scores every result transaction.
// ============================================================================
module testbench;
    import rsa_pkg::*;

    // Slowest request is a full key scan; ~2000 requests plus idling stay well
    // under this limit, so it is generous.
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int POOL_SIZE   = 40;
    localparam int SETTLE      = 300;   // a bit more than one full scan

    typedef enum int {
        IDLE_OFF,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    logic [1:0]            in_mode   = MODE_QUERY;
    logic [KEY_W-1:0]      in_key    = '0;
    logic [IDX_W-1:0]      in_index  = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [SLOT_OUT_W-1:0] out_slot;
    logic [1:0]            out_status;
    logic                  out_is_live;
    logic                  out_clear_row;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_W-1:0]      cfg_data  = '0;

    int                    error_count;
    int                    outstanding;
    int                    cycle_count = 0;
    t_idle                 idle_mode   = IDLE_OFF;
    int                    slots_now   = CFG_RESET;   // stimulus-side copy of slots_in_use
    logic [KEY_W-1:0]      key_pool [POOL_SIZE];
    logic [KEY_W-1:0]      fill_keys [SLOTS];

    rule_slot_allocator u_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_mode       (in_mode),
        .i_rule_key   (in_key),
        .i_slot_index (in_index),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_slot       (out_slot),
        .o_status     (out_status),
        .o_is_live    (out_is_live),
        .o_clear_row  (out_clear_row),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data)
    );

    rsa_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_mode        (in_mode),
        .i_rule_key    (in_key),
        .i_slot_index  (in_index),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_slot        (out_slot),
        .i_status      (out_status),
        .i_is_live     (out_is_live),
        .i_clear_row   (out_clear_row),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_data    (cfg_data),
        .o_error_count (error_count),
        .o_outstanding (outstanding)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Watchdog: a hung handshake or a lost result ends here.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("rule_slot_allocator verification failed");
            $finish;
        end
    end

    // Result side back-pressure: 74% stall alone, 35% when both sides idle.
    always @(posedge clk) begin
        case (idle_mode)
            IDLE_RECEIVER: out_ready <= ($urandom_range(99) >= 74);
            IDLE_BOTH:     out_ready <= ($urandom_range(99) >= 35);
            default:       out_ready <= 1'b1;
        endcase
    end

    // One request transaction. Valid is only dropped for a sender gap, so a
    // back-to-back request never sees two assignments to in_valid in one step.
    task automatic send_request(input t_mode mode, input logic [KEY_W-1:0] key,
                                input logic [IDX_W-1:0] idx);
        int pct;
        pct = (idle_mode == IDLE_SENDER) ? 74 : (idle_mode == IDLE_BOTH) ? 35 : 0;
        if ($urandom_range(99) < pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < pct);
        end
        in_valid <= 1'b1;
        in_mode  <= mode;
        in_key   <= key;
        in_index <= idx;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // Hold off until every result has come back and the block is idle again.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0 || !in_ready) @(posedge clk);
    endtask

    task automatic write_slots_in_use(input int value);
        wait_drained();
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= CFG_W'(value);
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        slots_now = value;
    endtask

    // Random traffic over the first pool_n keys of the pool. Requests on pool
    // keys form alloc/lookup/free lifecycles; fresh keys only go to free and
    // look up as noise so they never leak slots.
    task automatic run_phase(input int cfg, input t_idle idle, input int count,
                             input int pool_n, input bit flush, input int drain_every);
        int               r;
        int               lim;
        t_mode            mode;
        logic [KEY_W-1:0] key;
        logic [IDX_W-1:0] idx;
        write_slots_in_use(cfg);
        idle_mode <= idle;
        lim = (slots_now > SLOTS) ? SLOTS : slots_now;
        if (flush) begin
            // release whatever the pool holds, then refresh part of the pool
            for (int k = 0; k < POOL_SIZE; k++) begin
                send_request(MODE_FREE, key_pool[k], IDX_W'($urandom));
            end
            for (int k = 5; k < POOL_SIZE; k++) begin
                if ($urandom_range(1)) begin
                    key_pool[k] = {$urandom, $urandom};
                end
            end
        end
        for (int n = 0; n < count; n++) begin
            if (drain_every > 0 && n > 0 && n % drain_every == 0) begin
                wait_drained();
            end
            r    = $urandom_range(99);
            mode = (r < 35) ? MODE_ALLOC : (r < 60) ? MODE_FREE :
                   (r < 80) ? MODE_LOOKUP : MODE_QUERY;
            key  = key_pool[$urandom_range(pool_n - 1)];
            if (mode != MODE_ALLOC && $urandom_range(99) < 15) begin
                key = {$urandom, $urandom};
            end
            idx = IDX_W'($urandom);
            if (mode == MODE_QUERY) begin
                r = $urandom_range(99);
                if (r < 60) begin
                    idx = IDX_W'($urandom_range(lim + 3));
                end else if (r < 85) begin
                    idx = IDX_W'($urandom_range(SLOTS - 1));
                end
            end
            send_request(mode, key, idx);
        end
    endtask

    initial begin : stimulus
        int               j;
        logic [KEY_W-1:0] tmp;

        key_pool[0] = 64'h8000_0000_0000_0001;
        key_pool[1] = 64'hAAAA_AAAA_AAAA_AAAA;
        key_pool[2] = 64'h5555_5555_5555_5555;
        key_pool[3] = 64'h0;
        key_pool[4] = '1;
        for (int k = 5; k < POOL_SIZE; k++) begin
            key_pool[k] = {$urandom, $urandom};
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset limit of 256 slots, no idling.
        send_request(MODE_QUERY,  '0, '0);                   // empty table
        send_request(MODE_LOOKUP, '0, '1);                   // unknown key
        send_request(MODE_FREE,   '1, '0);                   // free of unknown key
        send_request(MODE_ALLOC,  '0, '1);                   // claims slot 0
        send_request(MODE_ALLOC,  '1, '0);                   // claims slot 1
        send_request(MODE_ALLOC,  '0, '0);                   // existing slot 0
        send_request(MODE_LOOKUP, '1, '0);
        send_request(MODE_QUERY,  '0, 16'd1);
        send_request(MODE_QUERY,  '0, 16'hFFFF);             // far out of range
        send_request(MODE_QUERY,  '0, 16'd256);              // just past the table
        send_request(MODE_FREE,   '0, '0);
        send_request(MODE_QUERY,  '0, '0);                   // freed slot reads dead
        send_request(MODE_ALLOC,  64'h8000_0000_0000_0001, '0);  // reuses slot 0
        send_request(MODE_FREE,   '0, '0);                   // already freed
        send_request(MODE_ALLOC,  64'h5555_5555_5555_5555, '0);
        send_request(MODE_FREE,   '1, '0);
        send_request(MODE_ALLOC,  64'hAAAA_AAAA_AAAA_AAAA, '0);  // lowest hole is slot 1
        send_request(MODE_LOOKUP, 64'h5555_5555_5555_5555, '0);

        // Fill the whole table so slot 255 and the full status are reached.
        write_slots_in_use(SLOTS);
        idle_mode <= IDLE_SENDER;
        for (int k = 0; k < SLOTS; k++) begin
            fill_keys[k] = {$urandom, $urandom};
            send_request(MODE_ALLOC, fill_keys[k], IDX_W'($urandom));
        end
        send_request(MODE_ALLOC, {$urandom, $urandom}, '0);
        send_request(MODE_QUERY, '0, 16'd255);

        // Lower the limit under a full table: search still covers every live
        // slot, queries above the limit read dead, new claims report full.
        write_slots_in_use(16);
        idle_mode <= IDLE_RECEIVER;
        send_request(MODE_QUERY,  '0, 16'd20);
        send_request(MODE_QUERY,  '0, 16'd15);
        send_request(MODE_LOOKUP, fill_keys[SLOTS-1], '0);
        send_request(MODE_ALLOC,  {$urandom, $urandom}, '0);
        for (int k = SLOTS - 1; k > 0; k--) begin
            j            = $urandom_range(k);
            tmp          = fill_keys[k];
            fill_keys[k] = fill_keys[j];
            fill_keys[j] = tmp;
        end
        for (int k = 0; k < SLOTS; k++) begin
            send_request(MODE_FREE, fill_keys[k], IDX_W'($urandom));
        end

        // Random phases: limit, idling, length, pool size, flush, drain period.
        // The drain period gives the sender full pauses in one phase.
        run_phase(256,                    IDLE_OFF,      200, 40, 1'b0, 0);
        run_phase(4,                      IDLE_SENDER,   200,  8, 1'b1, 0);
        run_phase(0,                      IDLE_RECEIVER, 130,  6, 1'b0, 0);
        run_phase(511,                    IDLE_BOTH,     200, 24, 1'b0, 0);
        run_phase(1,                      IDLE_OFF,      120,  4, 1'b1, 0);
        run_phase($urandom_range(2, 40),  IDLE_SENDER,   180, 12, 1'b1, 25);
        run_phase(300,                    IDLE_RECEIVER, 130, 20, 1'b0, 0);
        run_phase(256,                    IDLE_BOTH,     150, 40, 1'b0, 0);

        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        if (error_count == 0 && outstanding == 0) begin
            $display("rule_slot_allocator verification clean");
        end else begin
            $display("rule_slot_allocator verification failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/rsa_pkg.sv
sv/rsa_ram.sv
sv/rsa_ctrl.sv
sv/rsa_dp.sv
sv/rule_slot_allocator.sv
tb/rsa_checker.sv
tb/testbench.sv
